FILE: sv/pts_pkg.sv
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types and constants of the polynomial Taylor shift block.
// ----------------------------------------------------------------------------
package pts_pkg;

	// Coefficient width, fixed by the payload structs.
	localparam int COEFF_WIDTH = 32;

	// Default coefficient capacity.
	localparam int MAX_LEN_DEFAULT = 64;

	// Configuration port.
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;

	// Register indexes, by word address.
	localparam logic REG_SHIFT_VALUE = 1'b0;

	typedef struct packed {
		logic signed [COEFF_WIDTH-1:0] coeff_in;
		logic                          last_in;
	} item_t;

	typedef struct packed {
		logic signed [COEFF_WIDTH-1:0] coeff_out;
		logic                          last_out;
		logic                          truncated;
	} result_t;

	// Multiply-add request: sum = acc + c * mul.
	typedef struct packed {
		logic                   valid;
		logic [COEFF_WIDTH-1:0] acc;
		logic [COEFF_WIDTH-1:0] mul;
	} mac_req_t;

	typedef struct packed {
		logic                   valid;
		logic [COEFF_WIDTH-1:0] sum;
	} mac_rsp_t;

endpackage

FILE: sv/pts_mac.sv
// ----------------------------------------------------------------------------
// pts_mac
// Two-stage multiply-add modulo 2^COEFF_WIDTH: product registered, then add.
// ----------------------------------------------------------------------------
module pts_mac (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [pts_pkg::COEFF_WIDTH-1:0] shift_value,
	input  pts_pkg::mac_req_t               req,
	output pts_pkg::mac_rsp_t               rsp
);

	logic [pts_pkg::COEFF_WIDTH-1:0] prod;
	logic [pts_pkg::COEFF_WIDTH-1:0] prod_s1;
	logic [pts_pkg::COEFF_WIDTH-1:0] acc_s1;
	logic                            valid_s1;

	// Only the low half of the product survives the modulus.
	assign prod = pts_pkg::COEFF_WIDTH'(req.mul * shift_value);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod;
		acc_s1  <= req.acc;
	end

	assign rsp.valid = valid_s1;
	assign rsp.sum   = acc_s1 + prod_s1;

endmodule

FILE: sv/pts_apb.sv
// ----------------------------------------------------------------------------
// pts_apb
// APB-style register file holding the shift constant.
// ----------------------------------------------------------------------------
module pts_apb (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [pts_pkg::CFG_ADDR_W-1:0]  paddr,
	input  logic [pts_pkg::CFG_DATA_W-1:0]  pwdata,
	output logic [pts_pkg::CFG_DATA_W-1:0]  prdata,
	output logic                            pready,
	output logic [pts_pkg::COEFF_WIDTH-1:0] shift_value
);

	logic signed [pts_pkg::CFG_DATA_W-1:0] shift_value_q;
	logic                                  hit;

	// Word address selects the register; byte lanes are ignored.
	assign hit    = (paddr[2] == pts_pkg::REG_SHIFT_VALUE);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_value_q <= '0;
		end else if (psel && penable && pwrite && pready && hit) begin
			shift_value_q <= pwdata;
		end
	end

	assign prdata      = hit ? shift_value_q : '0;
	// Sign-extend or reduce to the coefficient width.
	assign shift_value = pts_pkg::COEFF_WIDTH'(shift_value_q);

endmodule

FILE: sv/pts_engine.sv
// ----------------------------------------------------------------------------
// pts_engine
// Coefficient memory with load, Horner pass and emission sequencer.
// ----------------------------------------------------------------------------
module pts_engine #(
	parameter int MAX_LEN = pts_pkg::MAX_LEN_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [pts_pkg::COEFF_WIDTH-1:0] shift_value,
	input  logic                            item_valid,
	output logic                            item_ready,
	input  pts_pkg::item_t                  item,
	output logic                            result_valid,
	input  logic                            result_ready,
	output pts_pkg::result_t                result
);

	localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int CW = $clog2(MAX_LEN + 1);
	localparam int W  = pts_pkg::COEFF_WIDTH;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_PASS,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	state_t state_q;

	logic [CW-1:0] count_q;
	logic [CW-1:0] n_q;
	logic [AW-1:0] i_q;
	logic [AW-1:0] rd_q;
	logic [AW-1:0] k_q;
	logic          ovf_q;

	logic [W-1:0]  mem [MAX_LEN];
	logic [W-1:0]  rdata_q;
	logic [W-1:0]  prev_q;
	logic          rvalid_s1;
	logic          rfirst_s1;
	logic          remit_s1;
	logic          elast_s1;
	logic          etrunc_s1;
	logic [AW-1:0] raddr_s1;
	logic [AW-1:0] dst_s2;

	logic          accept;
	logic          has_room;
	logic [CW-1:0] cnt_next;
	logic          pass_end;
	logic          emit_issue;
	logic          emit_end;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic          load_we;

	pts_pkg::mac_req_t mac_req;
	pts_pkg::mac_rsp_t mac_rsp;

	assign item_ready = (state_q == ST_LOAD);
	assign accept     = item_valid && item_ready;
	assign has_room   = (count_q < CW'(MAX_LEN));
	assign cnt_next   = has_room ? (count_q + CW'(1)) : count_q;
	assign load_we    = accept && has_room;

	assign pass_end   = (CW'(rd_q) == (n_q - CW'(1)));
	assign emit_issue = (state_q == ST_EMIT) && !remit_s1 && (!result_valid || result_ready);
	assign emit_end   = (CW'(k_q) == (n_q - CW'(1)));

	assign rd_en   = (state_q == ST_PASS) || emit_issue;
	assign rd_addr = (state_q == ST_PASS) ? rd_q : k_q;

	// Sequencer with the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_LOAD;
			count_q      <= '0;
			n_q          <= '0;
			i_q          <= '0;
			rd_q         <= '0;
			k_q          <= '0;
			ovf_q        <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (remit_s1) begin
				result_valid <= 1'b1;
			end else if (result_ready) begin
				result_valid <= 1'b0;
			end
			case (state_q)
				ST_LOAD: begin
					if (accept) begin
						count_q <= cnt_next;
						if (!has_room) begin
							ovf_q <= 1'b1;
						end
						if (item.last_in) begin
							n_q <= cnt_next;
							k_q <= '0;
							if (cnt_next >= CW'(2)) begin
								i_q     <= AW'(cnt_next - CW'(2));
								rd_q    <= AW'(cnt_next - CW'(2));
								state_q <= ST_PASS;
							end else begin
								state_q <= ST_EMIT;
							end
						end
					end
				end
				ST_PASS: begin
					if (pass_end) begin
						state_q <= ST_DRAIN;
					end else begin
						rd_q <= rd_q + AW'(1);
					end
				end
				ST_DRAIN: begin
					// Hold until every write of this pass has landed.
					if (!rvalid_s1 && !mac_rsp.valid) begin
						if (i_q == '0) begin
							state_q <= ST_EMIT;
						end else begin
							i_q     <= i_q - AW'(1);
							rd_q    <= i_q - AW'(1);
							state_q <= ST_PASS;
						end
					end
				end
				ST_EMIT: begin
					if (emit_issue) begin
						if (emit_end) begin
							count_q <= '0;
							ovf_q   <= 1'b0;
							state_q <= ST_LOAD;
						end else begin
							k_q <= k_q + AW'(1);
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// Read pipeline flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvalid_s1 <= 1'b0;
			remit_s1  <= 1'b0;
		end else begin
			rvalid_s1 <= rd_en;
			remit_s1  <= emit_issue;
		end
	end

	always_ff @(posedge clk) begin
		raddr_s1  <= rd_addr;
		rfirst_s1 <= (rd_q == i_q);
		elast_s1  <= emit_end;
		etrunc_s1 <= ovf_q;
		dst_s2    <= raddr_s1 - AW'(1);
		if (rvalid_s1 && !remit_s1) begin
			prev_q <= rdata_q;
		end
		if (remit_s1) begin
			result.coeff_out <= rdata_q;
			result.last_out  <= elast_s1;
			result.truncated <= etrunc_s1;
		end
	end

	// Coefficient memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (load_we) begin
			mem[count_q[AW-1:0]] <= item.coeff_in;
		end else if (mac_rsp.valid) begin
			mem[dst_s2] <= mac_rsp.sum;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// a[j] += c * a[j+1], with a[j] held from the previous read.
	assign mac_req.valid = rvalid_s1 && !remit_s1 && !rfirst_s1;
	assign mac_req.acc   = prev_q;
	assign mac_req.mul   = rdata_q;

	pts_mac u_mac (
		.clk         (clk),
		.arst_n      (arst_n),
		.shift_value (shift_value),
		.req         (mac_req),
		.rsp         (mac_rsp)
	);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_LEN))
		else $error("coefficient count beyond capacity");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		mac_rsp.valid |-> (CW'(dst_s2) < (n_q - CW'(1))))
		else $error("multiply-add write beyond the polynomial");

	a_no_raw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PASS && mac_rsp.valid) |-> (dst_s2 != rd_q))
		else $error("pass read hits an entry still being written");

	a_emit_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		remit_s1 |-> !result_valid)
		else $error("emission read returned into an occupied result register");

	a_no_load_during_shift: assert property (@(posedge clk) disable iff (!arst_n)
		mac_rsp.valid |-> !load_we)
		else $error("load write collides with a multiply-add write");

endmodule

FILE: sv/polynomial_taylor_shift.sv
// ----------------------------------------------------------------------------
// polynomial_taylor_shift
// Rewrites a streamed integer polynomial f(x) as f(x+c) modulo 2^32.
// ----------------------------------------------------------------------------
//
//  channel   handshake                 payload                      role
//  item      item_valid / item_ready   coeff_in, last_in            coefficients in
//  result    result_valid / ready      coeff_out, last_out, trunc.  shifted coeffs out
//  config    psel/penable/pwrite       paddr, pwdata, prdata        shift_value at 0x0
//
//  Sequence for a polynomial of n stored coefficients: the load, then
//  passes i = n-2..0 of (n-i) reads, each followed by a drain, then
//  the emission of each coefficient. The memory read port, read once per
//  cycle during a pass, and the multiply-add register set the pace.
//  Reset: control state clears at once; the memory needs no clearing pass.
//  Stalls: the last result may wait in its register while the next
//  polynomial loads; a new emission waits for that register to free up.
//
module polynomial_taylor_shift #(
	parameter int MAX_LEN = pts_pkg::MAX_LEN_DEFAULT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration port
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [pts_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [pts_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [pts_pkg::CFG_DATA_W-1:0] prdata,
	output logic                           pready,
	// coefficient transactions in
	input  logic                           item_valid,
	output logic                           item_ready,
	input  pts_pkg::item_t                 item,
	// shifted coefficient transactions out
	output logic                           result_valid,
	input  logic                           result_ready,
	output pts_pkg::result_t               result
);

	// Shift constant at coefficient width.
	logic [pts_pkg::COEFF_WIDTH-1:0] shift_value;

	// Register file: hold c between polynomials.
	pts_apb u_apb (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.shift_value (shift_value)
	);

	// Engine: store coefficients, run the Horner passes in place, then
	// drain the memory lowest degree first through the result register.
	pts_engine #(
		.MAX_LEN (MAX_LEN)
	) u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.shift_value  (shift_value),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule
